>>> hdl/srpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpf_pkg: shared definitions for the short-range pair force pipeline
// Widths, register reset values, register indexes and the buses that run
// between the cells of the square-root and division rows.
// ----------------------------------------------------------------------------
package srpf_pkg;

  // Position and field widths.
  localparam int POS_BITS   = 24;
  localparam int CUT_W      = 23;
  localparam int GAIN_W     = 24;
  localparam int FORCE_W    = 49;
  localparam int CFG_W      = 24;

  // Derived datapath widths.
  localparam int MAG_W      = POS_BITS;
  localparam int D2_W       = 2 * POS_BITS;
  localparam int ROOT_W     = POS_BITS;
  localparam int SREM_W     = ROOT_W + 2;
  localparam int C2_W       = 2 * CUT_W;
  localparam int Q_W        = GAIN_W + CUT_W;
  localparam int QLO_W      = 24;
  localparam int QHI_W      = Q_W - QLO_W;
  localparam int PLO_W      = QLO_W + MAG_W;
  localparam int PHI_W      = QHI_W + MAG_W;
  localparam int NUM_W      = Q_W + MAG_W;
  localparam int SQRT_CELLS = ROOT_W;
  localparam int DIV_CELLS  = FORCE_W;

  // Register reset values.
  localparam logic [CUT_W-1:0]  CUT_RST  = CUT_W'(16777);
  localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(1000000);
  localparam logic [C2_W-1:0]   C2_RST   = C2_W'(CUT_RST) * C2_W'(CUT_RST);

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_CUTOFF = 1'b0,
    REG_GAIN   = 1'b1
  } cfg_reg_t;

  // Per-item flags that travel with the data.
  typedef struct packed {
    logic sign_x;
    logic sign_y;
    logic in_range;
    logic coincident;
  } side_t;

  // Link between square-root cells.
  typedef struct packed {
    logic              valid;
    logic [D2_W-1:0]   rad;
    logic [SREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
    logic [MAG_W-1:0]  mag_x;
    logic [MAG_W-1:0]  mag_y;
    side_t             side;
  } sqrt_bus_t;

  // Link between division cells; rad holds the dividend tail and the quotient.
  typedef struct packed {
    logic               valid;
    logic [ROOT_W-1:0]  rem_x;
    logic [ROOT_W-1:0]  rem_y;
    logic [FORCE_W-1:0] rad_x;
    logic [FORCE_W-1:0] rad_y;
    logic [ROOT_W-1:0]  divisor;
    side_t              side;
  } div_bus_t;

endpackage

>>> hdl/srpf_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpf_sqrt_cell: one root bit of the integer square root
// Brings in two radicand bits, tries the next root bit and passes the
// partial remainder and root to the next cell.
// ----------------------------------------------------------------------------
module srpf_sqrt_cell
  import srpf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  sqrt_bus_t cell_in,
  output sqrt_bus_t cell_out
);

  logic [SREM_W+1:0] rem_sh;
  logic [SREM_W+1:0] trial;
  logic              fits;
  sqrt_bus_t         data_nxt;
  sqrt_bus_t         data_r;
  logic              valid_r;

  // Trial subtraction of the candidate root bit.
  always_comb begin
    rem_sh   = {cell_in.rem, cell_in.rad[D2_W-1 -: 2]};
    trial    = (SREM_W+2)'({cell_in.root, 2'b01});
    fits     = (rem_sh >= trial);
    data_nxt = cell_in;
    data_nxt.rad = cell_in.rad << 2;
    if (fits) begin
      data_nxt.rem  = SREM_W'(rem_sh - trial);
      data_nxt.root = {cell_in.root[ROOT_W-2:0], 1'b1};
    end else begin
      data_nxt.rem  = SREM_W'(rem_sh);
      data_nxt.root = {cell_in.root[ROOT_W-2:0], 1'b0};
    end
  end

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= cell_in.valid;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  always_comb begin
    cell_out       = data_r;
    cell_out.valid = valid_r;
  end

endmodule

>>> hdl/srpf_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpf_div_cell: one quotient bit of the two force divisions
// Restoring division step by the distance for the x and y numerators.
// ----------------------------------------------------------------------------
module srpf_div_cell
  import srpf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  div_bus_t cell_in,
  output div_bus_t cell_out
);

  // Returns the new remainder, then the shifted tail with the quotient bit.
  function automatic logic [ROOT_W+FORCE_W-1:0] div_step(
    input logic [ROOT_W-1:0]  rem,
    input logic [FORCE_W-1:0] rad,
    input logic [ROOT_W-1:0]  divisor
  );
    logic [ROOT_W:0] sh;
    logic            fits;
    sh   = {rem, rad[FORCE_W-1]};
    fits = (sh >= {1'b0, divisor});
    if (fits) begin
      sh = sh - {1'b0, divisor};
    end
    return {sh[ROOT_W-1:0], rad[FORCE_W-2:0], fits};
  endfunction

  div_bus_t data_nxt;
  div_bus_t data_r;
  logic     valid_r;

  // One step on each axis.
  always_comb begin
    data_nxt = cell_in;
    {data_nxt.rem_x, data_nxt.rad_x} = div_step(cell_in.rem_x, cell_in.rad_x, cell_in.divisor);
    {data_nxt.rem_y, data_nxt.rad_y} = div_step(cell_in.rem_y, cell_in.rad_y, cell_in.divisor);
  end

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= cell_in.valid;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  always_comb begin
    cell_out       = data_r;
    cell_out.valid = valid_r;
  end

endmodule

>>> hdl/short_range_pair_force_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// short_range_pair_force_top: periodic minimum-image spring pair force
// Each transfer on the input channel brings two particle positions; each
// transfer on the output channel returns the force on the second particle.
//
// Usage: present a pair on in_* with in_valid high; it is taken at an edge
// where in_stall is low. One result per pair leaves on out_* in the same
// order, and is taken at an edge where out_valid is high and out_stall low.
// From input transfer to out_valid a pair passes the input register,
// square, sum and compare, 24 square-root cells, overlap product, two
// partial-product stages, 49 division cells and the output register.
// Throughput is one pair per cycle while in_stall is low; every stage is
// a register in one shared pipeline. When the receiver stalls with a result
// waiting, the pipeline keeps moving as long as its last division cell is
// empty, and stops otherwise; in_stall follows from that.
// Reset clears all valid flags and loads cutoff = 16777 and
// spring_gain = 1000000. Write the registers through cfg_* only while no
// pair is in flight; the squared cutoff is then registered from cutoff_r.
// ----------------------------------------------------------------------------
module short_range_pair_force_top
  import srpf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  // Input channel.
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [POS_BITS-1:0]       in_self_x,
  input  logic [POS_BITS-1:0]       in_self_y,
  input  logic [POS_BITS-1:0]       in_other_x,
  input  logic [POS_BITS-1:0]       in_other_y,
  // Result channel.
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [FORCE_W-1:0] out_force_x,
  output logic signed [FORCE_W-1:0] out_force_y,
  output logic                      out_in_range,
  output logic                      out_coincident,
  // Configuration port.
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [CFG_W-1:0]          cfg_data
);

  // Configuration registers.
  logic [CUT_W-1:0]  cutoff_r;
  logic [GAIN_W-1:0] gain_r;
  logic [C2_W-1:0]   c2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= CUT_RST;
      gain_r   <= GAIN_RST;
      c2_r     <= C2_RST;
    end else begin
      c2_r <= C2_W'(cutoff_r) * C2_W'(cutoff_r);
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_CUTOFF: cutoff_r <= cfg_data[CUT_W-1:0];
          REG_GAIN:   gain_r   <= cfg_data[GAIN_W-1:0];
          default:    cutoff_r <= cutoff_r;
        endcase
      end
    end
  end

  // Pipeline advance control.
  logic     adv;
  logic     take;
  div_bus_t div_link [DIV_CELLS+1];

  assign take     = !out_valid || !out_stall;
  assign adv      = take || !div_link[DIV_CELLS].valid;
  assign in_stall = !adv;

  // Stage 0: minimum-image difference, sign and magnitude.
  logic [POS_BITS-1:0] dx_nxt, dy_nxt;
  logic                s0_valid_r;
  logic                s0_sx_r, s0_sy_r;
  logic [MAG_W-1:0]    s0_mx_r, s0_my_r;

  assign dx_nxt = in_other_x - in_self_x;
  assign dy_nxt = in_other_y - in_self_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_sx_r <= dx_nxt[POS_BITS-1];
      s0_sy_r <= dy_nxt[POS_BITS-1];
      s0_mx_r <= dx_nxt[POS_BITS-1] ? MAG_W'(-dx_nxt) : MAG_W'(dx_nxt);
      s0_my_r <= dy_nxt[POS_BITS-1] ? MAG_W'(-dy_nxt) : MAG_W'(dy_nxt);
    end
  end

  // Stage 1: squares.
  logic             s1_valid_r;
  logic             s1_sx_r, s1_sy_r;
  logic [MAG_W-1:0] s1_mx_r, s1_my_r;
  logic [D2_W-1:0]  s1_sqx_r, s1_sqy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sx_r  <= s0_sx_r;
      s1_sy_r  <= s0_sy_r;
      s1_mx_r  <= s0_mx_r;
      s1_my_r  <= s0_my_r;
      s1_sqx_r <= D2_W'(s0_mx_r) * D2_W'(s0_mx_r);
      s1_sqy_r <= D2_W'(s0_my_r) * D2_W'(s0_my_r);
    end
  end

  // Stage 2: squared distance and range flags.
  logic [D2_W-1:0] d2_nxt;
  sqrt_bus_t       s2_r;
  logic            s2_valid_r;

  assign d2_nxt = s1_sqx_r + s1_sqy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r.valid           <= 1'b0;
      s2_r.rad             <= d2_nxt;
      s2_r.rem             <= '0;
      s2_r.root            <= '0;
      s2_r.mag_x           <= s1_mx_r;
      s2_r.mag_y           <= s1_my_r;
      s2_r.side.sign_x     <= s1_sx_r;
      s2_r.side.sign_y     <= s1_sy_r;
      s2_r.side.coincident <= (d2_nxt == '0);
      s2_r.side.in_range   <= (d2_nxt != '0) && (d2_nxt < D2_W'(c2_r));
    end
  end

  // Square-root row.
  sqrt_bus_t sq_link [SQRT_CELLS+1];

  always_comb begin
    sq_link[0]       = s2_r;
    sq_link[0].valid = s2_valid_r;
  end

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
    srpf_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_in  (sq_link[i]),
      .cell_out (sq_link[i+1])
    );
  end

  // Overlap product: spring_gain * (cutoff - dist).
  sqrt_bus_t        sq_end;
  logic [CUT_W-1:0] overlap;
  logic             qs_valid_r;
  logic [Q_W-1:0]   qs_q_r;
  logic [MAG_W-1:0] qs_mx_r, qs_my_r;
  logic [ROOT_W-1:0] qs_dist_r;
  side_t            qs_side_r;

  assign sq_end  = sq_link[SQRT_CELLS];
  assign overlap = CUT_W'(ROOT_W'(cutoff_r) - sq_end.root);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qs_valid_r <= 1'b0;
    end else if (adv) begin
      qs_valid_r <= sq_end.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qs_q_r    <= Q_W'(gain_r) * Q_W'(overlap);
      qs_mx_r   <= sq_end.mag_x;
      qs_my_r   <= sq_end.mag_y;
      qs_dist_r <= sq_end.root;
      qs_side_r <= sq_end.side;
    end
  end

  // Partial products of the numerators.
  logic              m1_valid_r;
  logic [PLO_W-1:0]  m1_lox_r, m1_loy_r;
  logic [PHI_W-1:0]  m1_hix_r, m1_hiy_r;
  logic [ROOT_W-1:0] m1_dist_r;
  side_t             m1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_valid_r <= 1'b0;
    end else if (adv) begin
      m1_valid_r <= qs_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_lox_r  <= PLO_W'(qs_q_r[QLO_W-1:0]) * PLO_W'(qs_mx_r);
      m1_loy_r  <= PLO_W'(qs_q_r[QLO_W-1:0]) * PLO_W'(qs_my_r);
      m1_hix_r  <= PHI_W'(qs_q_r[Q_W-1:QLO_W]) * PHI_W'(qs_mx_r);
      m1_hiy_r  <= PHI_W'(qs_q_r[Q_W-1:QLO_W]) * PHI_W'(qs_my_r);
      m1_dist_r <= qs_dist_r;
      m1_side_r <= qs_side_r;
    end
  end

  // Numerator sum, split into starting remainder and dividend tail.
  logic [NUM_W-1:0] num_x, num_y;
  div_bus_t         m2_r;
  logic             m2_valid_r;

  assign num_x = NUM_W'(m1_lox_r) + (NUM_W'(m1_hix_r) << QLO_W);
  assign num_y = NUM_W'(m1_loy_r) + (NUM_W'(m1_hiy_r) << QLO_W);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_valid_r <= 1'b0;
    end else if (adv) begin
      m2_valid_r <= m1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_r.valid   <= 1'b0;
      m2_r.rem_x   <= ROOT_W'(num_x[NUM_W-1:FORCE_W]);
      m2_r.rem_y   <= ROOT_W'(num_y[NUM_W-1:FORCE_W]);
      m2_r.rad_x   <= num_x[FORCE_W-1:0];
      m2_r.rad_y   <= num_y[FORCE_W-1:0];
      m2_r.divisor <= m1_dist_r;
      m2_r.side    <= m1_side_r;
    end
  end

  // Division row.
  always_comb begin
    div_link[0]       = m2_r;
    div_link[0].valid = m2_valid_r;
  end

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    srpf_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_in  (div_link[i]),
      .cell_out (div_link[i+1])
    );
  end

  // Output register: sign and range select.
  div_bus_t           dv_end;
  logic [FORCE_W-1:0] fx_nxt, fy_nxt;
  logic               out_valid_r;
  logic [FORCE_W-1:0] out_fx_r, out_fy_r;
  logic               out_in_range_r, out_coincident_r;

  assign dv_end = div_link[DIV_CELLS];

  always_comb begin
    fx_nxt = '0;
    fy_nxt = '0;
    if (dv_end.side.in_range) begin
      fx_nxt = dv_end.side.sign_x ? -dv_end.rad_x : dv_end.rad_x;
      fy_nxt = dv_end.side.sign_y ? -dv_end.rad_y : dv_end.rad_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= dv_end.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_fx_r         <= fx_nxt;
      out_fy_r         <= fy_nxt;
      out_in_range_r   <= dv_end.side.in_range;
      out_coincident_r <= dv_end.side.coincident;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_force_x    = out_fx_r;
  assign out_force_y    = out_fy_r;
  assign out_in_range   = out_in_range_r;
  assign out_coincident = out_coincident_r;

endmodule

>>> hdl/srpf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpf_checker: port-level checks for the pair force block
// Watches the top-level ports and flags results or handshakes that the
// pipeline should never produce.
// ----------------------------------------------------------------------------
module srpf_checker
  import srpf_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [FORCE_W-1:0] out_force_x,
  input logic signed [FORCE_W-1:0] out_force_y,
  input logic                      out_in_range,
  input logic                      out_coincident
);

  // A result is never both in range and coincident.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_in_range && out_coincident))
    else $error("in_range and coincident both set");

  // Out-of-range results carry no force.
  a_zero_force: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_in_range) |-> (out_force_x == '0 && out_force_y == '0))
    else $error("nonzero force outside range");

  // The input side only stalls when the result side does.
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output free");

  // Nothing leaves right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result stays valid and keeps its x force.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_force_x)))
    else $error("stalled result changed");

endmodule

bind short_range_pair_force_top srpf_checker u_srpf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_force_x    (out_force_x),
  .out_force_y    (out_force_y),
  .out_in_range   (out_in_range),
  .out_coincident (out_coincident)
);

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for short_range_pair_force_top
// Drives particle pairs through the input channel, mostly under random idling on
// both sides, predicts each minimum-image spring force from the register settings
// in force at the time of the transfer, and checks every result in order.
// ----------------------------------------------------------------------------
module tb;
  import srpf_pkg::*;

  typedef struct packed {
    logic [POS_BITS-1:0] sx;
    logic [POS_BITS-1:0] sy;
    logic [POS_BITS-1:0] ox;
    logic [POS_BITS-1:0] oy;
  } pair_t;

  typedef struct packed {
    logic signed [FORCE_W-1:0] fx;
    logic signed [FORCE_W-1:0] fy;
    logic                      in_range;
    logic                      coincident;
  } force_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [POS_BITS-1:0] in_self_x = '0, in_self_y = '0, in_other_x = '0, in_other_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [FORCE_W-1:0] out_force_x, out_force_y;
  logic out_in_range, out_coincident;
  logic cfg_we = 1'b0;
  cfg_reg_t cfg_index = REG_CUTOFF;
  logic [CFG_W-1:0] cfg_data = '0;

  // Register copies and checking state.
  logic [CUT_W-1:0]  cutoff_q = CUT_RST;
  logic [GAIN_W-1:0] gain_q = GAIN_RST;
  pair_t  pending_pairs[$];
  force_t expected_forces[$];
  int     errors = 0;
  bit     no_idle = 1'b0;
  int     in_gap = 0;
  int     out_gap = 0;

  short_range_pair_force_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_self_x(in_self_x), .in_self_y(in_self_y),
    .in_other_x(in_other_x), .in_other_y(in_other_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_force_x(out_force_x), .out_force_y(out_force_y),
    .out_in_range(out_in_range), .out_coincident(out_coincident),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Floor of the square root by bitwise trial.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] t;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      t = root | (64'd1 << b);
      if (t * t <= v) root = t;
    end
    return root;
  endfunction

  // Force on the second particle for one pair under the current registers.
  function automatic force_t pair_force(input pair_t p);
    force_t r;
    logic signed [POS_BITS-1:0] dx, dy;
    logic [POS_BITS-1:0] ax, ay;
    logic [63:0] d2, c2, dist_v, q;
    logic [127:0] mx, my;
    dx = p.ox - p.sx;
    dy = p.oy - p.sy;
    ax = dx[POS_BITS-1] ? -dx : dx;
    ay = dy[POS_BITS-1] ? -dy : dy;
    d2 = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay);
    c2 = 64'(cutoff_q) * 64'(cutoff_q);
    r = '0;
    if (d2 == 0) begin
      r.coincident = 1'b1;
    end else if (d2 < c2) begin
      dist_v = floor_sqrt(d2);
      q = 64'(gain_q) * (64'(cutoff_q) - dist_v);
      mx = 128'(q) * 128'(ax) / 128'(dist_v);
      my = 128'(q) * 128'(ay) / 128'(dist_v);
      r.fx = dx[POS_BITS-1] ? -mx[FORCE_W-1:0] : mx[FORCE_W-1:0];
      r.fy = dy[POS_BITS-1] ? -my[FORCE_W-1:0] : my[FORCE_W-1:0];
      r.in_range = 1'b1;
    end
    return r;
  endfunction

  // Driver: records the prediction of each transfer and presents the next pair.
  always @(posedge clk) begin
    pair_t p;
    logic  nv;
    nv = in_valid;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_forces.push_back(pair_force({in_self_x, in_self_y, in_other_x, in_other_y}));
        nv = 1'b0;
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_pairs.size() > 0) begin
          p = pending_pairs.pop_front();
          in_self_x  <= p.sx;
          in_self_y  <= p.sy;
          in_other_x <= p.ox;
          in_other_y <= p.oy;
          nv = 1'b1;
          if (!no_idle && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 9);
        end
      end
    end
    in_valid <= nv;
  end

  // Monitor: compares each result transfer with the oldest prediction.
  always @(posedge clk) begin
    force_t e;
    logic   ns;
    ns = out_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_forces.size() == 0) begin
          $display("%0t: unexpected result fx=%0d fy=%0d", $time, out_force_x, out_force_y);
          errors++;
        end else begin
          e = expected_forces.pop_front();
          if (out_force_x !== e.fx) begin
            $display("%0t: force_x expected %0d actual %0d", $time, e.fx, out_force_x);
            errors++;
          end
          if (out_force_y !== e.fy) begin
            $display("%0t: force_y expected %0d actual %0d", $time, e.fy, out_force_y);
            errors++;
          end
          if (out_in_range !== e.in_range) begin
            $display("%0t: in_range expected %0b actual %0b", $time, e.in_range, out_in_range);
            errors++;
          end
          if (out_coincident !== e.coincident) begin
            $display("%0t: coincident expected %0b actual %0b", $time, e.coincident,
                     out_coincident);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        ns = 1'b1;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 8);
        ns = 1'b1;
      end else begin
        ns = 1'b0;
      end
    end
    out_stall <= ns;
  end

  task automatic add_pair(input logic [23:0] sx, sy, ox, oy);
    pending_pairs.push_back({sx, sy, ox, oy});
  endtask

  // Random pair: mostly a neighbor within the cutoff box, sometimes anywhere.
  task automatic add_random_pair();
    int c, ox, oy;
    logic [23:0] sx, sy;
    sx = 24'($urandom);
    sy = 24'($urandom);
    if ($urandom_range(0, 9) < 7) begin
      c = (cutoff_q > 23'h7fffff) ? 23'h7fffff : cutoff_q;
      ox = $urandom_range(0, 2 * c) - c;
      oy = $urandom_range(0, 2 * c) - c;
      if ($urandom_range(0, 15) == 0) oy = 0;
      add_pair(sx, sy, sx + 24'(ox), sy + 24'(oy));
    end else begin
      add_pair(sx, sy, 24'($urandom), 24'($urandom));
    end
  endtask

  // Waits until every pair has been sent and every result checked, then idles before returning.
  task automatic drain();
    while (pending_pairs.size() != 0 || in_valid || expected_forces.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CUTOFF) cutoff_q = val[CUT_W-1:0];
    else gain_q = val[GAIN_W-1:0];
    repeat (2) @(posedge clk);
  endtask

  task automatic random_items(input int n);
    repeat (n) add_random_pair();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pairs under the reset registers.
    add_pair(24'd0, 24'd0, 24'd0, 24'd0);
    add_pair(24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff);
    add_pair(24'd0, 24'd0, 24'hffffff, 24'd0);
    add_pair(24'hffffff, 24'hffffff, 24'd0, 24'd0);
    add_pair(24'd100, 24'd200, 24'd5100, 24'd200);
    add_pair(24'd100, 24'd200, 24'd100, 24'd9000);
    add_pair(24'd0, 24'd0, 24'd16776, 24'd0);
    add_pair(24'd0, 24'd0, 24'd16777, 24'd0);
    add_pair(24'd0, 24'd0, 24'd12000, 24'd12000);
    add_pair(24'd0, 24'd0, 24'h800000, 24'd0);
    add_pair(24'h123456, 24'h654321, 24'h123455, 24'h654322);
    add_pair(24'h400000, 24'h400000, 24'hc00000, 24'hc00000);
    drain();

    // Widest cutoff and gain.
    write_reg(REG_CUTOFF, 24'h7fffff);
    write_reg(REG_GAIN, 24'hffffff);
    add_pair(24'd0, 24'd0, 24'h800000, 24'd0);
    add_pair(24'd0, 24'd0, 24'h7fffff, 24'd0);
    add_pair(24'd0, 24'd0, 24'h800001, 24'd0);
    add_pair(24'd0, 24'd0, 24'd1, 24'd0);
    add_pair(24'd0, 24'd0, 24'h5a0000, 24'h5a0000);
    add_pair(24'hffffff, 24'd0, 24'd0, 24'hffffff);
    random_items(300);
    drain();

    // Unit cutoff: nothing can be in range.
    write_reg(REG_CUTOFF, 24'd1);
    write_reg(REG_GAIN, CFG_W'($urandom));
    add_pair(24'd5, 24'd5, 24'd6, 24'd5);
    add_pair(24'd5, 24'd5, 24'd5, 24'd5);
    random_items(150);
    drain();

    // Zero cutoff through a write whose top bit falls outside the register.
    write_reg(REG_CUTOFF, 24'h800000);
    add_pair(24'd7, 24'd7, 24'd7, 24'd7);
    add_pair(24'd7, 24'd7, 24'd8, 24'd7);
    random_items(100);
    drain();

    // Zero gain.
    write_reg(REG_CUTOFF, CFG_W'($urandom_range(1000, 2000000)));
    write_reg(REG_GAIN, 24'd0);
    random_items(200);
    drain();

    // Several random settings.
    repeat (5) begin
      write_reg(REG_CUTOFF, CFG_W'($urandom_range(1, 200000)));
      write_reg(REG_GAIN, CFG_W'($urandom));
      random_items(100);
      drain();
    end

    // Last stretch with no idling on either side.
    write_reg(REG_CUTOFF, CFG_W'($urandom));
    write_reg(REG_GAIN, CFG_W'($urandom));
    no_idle = 1'b1;
    random_items(500);
    drain();

    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #20ms;
    $display("tb: FAIL");
    $finish;
  end

endmodule

>>> short_range_pair_force_top.f
hdl/srpf_pkg.sv
hdl/srpf_sqrt_cell.sv
hdl/srpf_div_cell.sv
hdl/short_range_pair_force_top.sv
hdl/srpf_checker.sv
verif/tb.sv
